### rtl/asf_pkg.sv
`default_nettype none

package asf_pkg;

   // Item kinds carried on the request tuser field.
   typedef enum logic [1:0] {
      KIND_PUSH    = 2'd0,
      KIND_PULL    = 2'd1,
      KIND_RESTART = 2'd2
   } kind_type;

   // Field widths fixed by the stream format.
   localparam int SampleW   = 16;
   localparam int LevelW    = 11;
   localparam int UnderrunW = 16;
   localparam int RspDataW  = 64;
   localparam int CsrDataW  = 16;

   // One classified word on its way from the front end to the fade path.
   typedef struct packed {
      logic                 supplied;
      logic                 accepted;
      logic [UnderrunW-1:0] underrun_total;
      logic [LevelW-1:0]    fill_level;
      logic [SampleW-1:0]   left;
      logic [SampleW-1:0]   right;
   } job_type;

endpackage

`default_nettype wire

### rtl/audio_sink_fifo_with_starve_recovery_top.sv
// Channel   Dir   Ports                              Contents
// req       in    req_tvalid/tready/tdata/tuser      one word: push, pull or restart
// rsp       out   rsp_tvalid/tready/tdata            one result word per request word
// csr       in    csr_tvalid/tready/tdata            start threshold write
//
// One request word is taken per cycle while req_tready is high; results stay in order.
// The frame store is a single-port RAM; a word uses it for either a write or a read.
// A four-entry queue sits between the front end and the two-stage fade multiply.
// Reset is synchronous; the frame store itself is not cleared.
// With rsp_tready low the fade stages fill, then the queue, then req_tready drops.
`default_nettype none

module audio_sink_fifo_with_starve_recovery_top #(
   parameter int FIFO_DEPTH = 1024,
   parameter int FADE_FRAMES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // left_in [15:0], right_in [31:16]
   input  logic [1:0]  req_tuser,   // kind [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // left_out [15:0], right_out [31:16], supplied [32],
                                    // accepted [33], underrun_total [49:34],
                                    // fill_level [60:50], zero [63:61]
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [15:0] csr_tdata    // start_threshold [10:0], zero [15:11]
);

   localparam int NumW   = $clog2(FADE_FRAMES + 1);
   localparam int JobW   = $bits(asf_pkg::job_type);
   localparam int QWidth = JobW + NumW;
   localparam int QDepth = 4;

   logic                 job_valid;
   asf_pkg::job_type     job_data;
   logic [NumW-1:0]      job_num;
   logic                 q_full, q_afull, q_valid, q_ready;
   logic [QWidth-1:0]    q_rdata;
   asf_pkg::job_type     q_job;
   logic [NumW-1:0]      q_num;

   asf_front #(
      .FIFO_DEPTH (FIFO_DEPTH),
      .FADE_FRAMES(FADE_FRAMES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .csr_tvalid(csr_tvalid),
      .csr_tready(csr_tready),
      .csr_tdata (csr_tdata),
      .q_full    (q_full),
      .q_afull   (q_afull),
      .job_valid (job_valid),
      .job_data  (job_data),
      .job_num   (job_num)
   );

   asf_queue #(
      .WIDTH(QWidth),
      .DEPTH(QDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_valid),
      .wdata    ({job_num, job_data}),
      .pop_ready(q_ready),
      .rvalid   (q_valid),
      .rdata    (q_rdata),
      .full     (q_full),
      .afull    (q_afull)
   );

   // Split the queued word back into its parts.
   assign q_job = asf_pkg::job_type'(q_rdata[JobW-1:0]);
   assign q_num = q_rdata[QWidth-1:JobW];

   asf_back #(
      .FADE_FRAMES(FADE_FRAMES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_job     (q_job),
      .q_num     (q_num),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire

### rtl/asf_ram.sv
`default_nettype none

module asf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AddrW-1:0] addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single port, registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### rtl/asf_queue.sv
`default_nettype none

module asf_queue #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4,
   localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CntW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop_ready,
   output logic             rvalid,
   output logic [WIDTH-1:0] rdata,
   output logic             full,
   output logic             afull
);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [IdxW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [IdxW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             pop;

   function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] p);
      next_idx = (p == IdxW'(DEPTH - 1)) ? '0 : p + IdxW'(1);
   endfunction

   assign rvalid = (count_ff != '0);
   assign pop    = rvalid && pop_ready;
   assign rdata  = entries_ff[rd_ptr_ff];
   assign full   = (count_ff == CntW'(DEPTH));
   assign afull  = (count_ff >= CntW'(DEPTH - 1));

   // Pointer and level update.
   always_comb begin
      wr_ptr_in = push ? next_idx(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_idx(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

### rtl/asf_front.sv
`default_nettype none

module asf_front #(
   parameter int FIFO_DEPTH = 1024,
   parameter int FADE_FRAMES = 64,
   localparam int NumW = $clog2(FADE_FRAMES + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [1:0]                       req_tuser,
   input  logic [31:0]                      req_tdata,
   input  logic                             csr_tvalid,
   output logic                             csr_tready,
   input  logic [asf_pkg::CsrDataW-1:0]     csr_tdata,
   input  logic                             q_full,
   input  logic                             q_afull,
   output logic                             job_valid,
   output asf_pkg::job_type                 job_data,
   output logic [NumW-1:0]                  job_num
);

   localparam int PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CntW = $clog2(FIFO_DEPTH + 1);
   localparam int CmpW = (CntW > asf_pkg::LevelW) ? CntW : asf_pkg::LevelW;
   localparam int UW   = asf_pkg::UnderrunW;

   logic [asf_pkg::LevelW-1:0] thr_ff;
   logic [PtrW-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [PtrW-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [CntW-1:0]            count_ff, count_in;
   logic                       waiting_ff, waiting_in;
   logic [NumW-1:0]            fade_left_ff, fade_left_in;
   logic [UW-1:0]              underrun_ff, underrun_in;
   logic                       pend_ff;
   logic                       pend_sup_ff, pend_acc_ff;
   logic [UW-1:0]              pend_under_ff;
   logic [asf_pkg::LevelW-1:0] pend_fill_ff;
   logic [NumW-1:0]            pend_num_ff, num_in;
   logic                       sup_in, acc_in;
   logic                       req_fire;
   logic                       recovered;
   logic [CmpW-1:0]            cnt_ext, thr_ext, fill_ext;
   logic                       ram_we;
   logic [PtrW-1:0]            ram_addr;
   logic [31:0]                ram_rdata;
   asf_pkg::kind_type          kind;

   function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
      next_ptr = (p == PtrW'(FIFO_DEPTH - 1)) ? '0 : p + PtrW'(1);
   endfunction

   // Hold off a new word when the queue has no slot left for it and the one in flight.
   // Nothing is taken while reset is held.
   assign req_tready = !reset && (pend_ff ? !q_afull : !q_full);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_tready = !reset;
   assign kind       = asf_pkg::kind_type'(req_tuser);

   assign cnt_ext   = CmpW'(count_ff);
   assign thr_ext   = CmpW'(thr_ff);
   assign recovered = !waiting_ff || (cnt_ext >= thr_ext);
   assign fill_ext  = CmpW'(count_in);

   // Classify the word and update ring state.
   always_comb begin
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      count_in     = count_ff;
      waiting_in   = waiting_ff;
      fade_left_in = fade_left_ff;
      underrun_in  = underrun_ff;
      ram_we       = 1'b0;
      ram_addr     = rd_ptr_ff;
      sup_in       = 1'b0;
      acc_in       = 1'b0;
      num_in       = NumW'(FADE_FRAMES);
      if (req_fire) begin
         case (kind)
            asf_pkg::KIND_PUSH: begin
               if (count_ff != CntW'(FIFO_DEPTH)) begin
                  ram_we    = 1'b1;
                  ram_addr  = wr_ptr_ff;
                  wr_ptr_in = next_ptr(wr_ptr_ff);
                  count_in  = count_ff + CntW'(1);
                  acc_in    = 1'b1;
               end
            end
            asf_pkg::KIND_PULL: begin
               if (recovered && count_ff != '0) begin
                  rd_ptr_in  = next_ptr(rd_ptr_ff);
                  count_in   = count_ff - CntW'(1);
                  waiting_in = 1'b0;
                  sup_in     = 1'b1;
                  if (fade_left_ff != '0) begin
                     num_in       = NumW'(FADE_FRAMES) - fade_left_ff + NumW'(1);
                     fade_left_in = fade_left_ff - NumW'(1);
                  end
               end else begin
                  // Starved while playing: count it, unless the count is saturated, and wait for the threshold.
                  if (recovered && underrun_ff != '1) begin
                     underrun_in = underrun_ff + UW'(1);
                  end
                  waiting_in = 1'b1;
               end
            end
            asf_pkg::KIND_RESTART: begin
               rd_ptr_in    = '0;
               wr_ptr_in    = '0;
               count_in     = '0;
               waiting_in   = 1'b1;
               fade_left_in = NumW'(FADE_FRAMES);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= asf_pkg::LevelW'(256);
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         count_ff     <= '0;
         waiting_ff   <= 1'b1;
         fade_left_ff <= NumW'(FADE_FRAMES);
         underrun_ff  <= '0;
         pend_ff      <= 1'b0;
      end else begin
         if (csr_tvalid && csr_tready) begin
            thr_ff <= csr_tdata[asf_pkg::LevelW-1:0];
         end
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         count_ff     <= count_in;
         waiting_ff   <= waiting_in;
         fade_left_ff <= fade_left_in;
         underrun_ff  <= underrun_in;
         pend_ff      <= req_fire;
      end
   end

   // Result fields are registered so that they line up with the registered frame store read.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         pend_sup_ff   <= sup_in;
         pend_acc_ff   <= acc_in;
         pend_under_ff <= underrun_in;
         pend_fill_ff  <= fill_ext[asf_pkg::LevelW-1:0];
         pend_num_ff   <= num_in;
      end
   end

   asf_ram #(
      .WIDTH(32),
      .DEPTH(FIFO_DEPTH)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(req_tdata),
      .rdata(ram_rdata)
   );

   // Silence unless a stored frame was read.
   assign job_valid               = pend_ff;
   assign job_num                 = pend_num_ff;
   assign job_data.supplied       = pend_sup_ff;
   assign job_data.accepted       = pend_acc_ff;
   assign job_data.underrun_total = pend_under_ff;
   assign job_data.fill_level     = pend_fill_ff;
   assign job_data.left           = pend_sup_ff ? ram_rdata[15:0] : '0;
   assign job_data.right          = pend_sup_ff ? ram_rdata[31:16] : '0;

`ifndef SYNTHESIS
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(FIFO_DEPTH))
      else $error("frame level above ring depth");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser == asf_pkg::KIND_RESTART |=> count_ff == '0 && waiting_ff)
      else $error("restart did not empty the ring");

   a_underrun_monotone: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> underrun_ff >= $past(underrun_ff))
      else $error("underrun count went down");

   a_push_stores: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser == asf_pkg::KIND_PUSH && count_ff != CntW'(FIFO_DEPTH)
      |=> count_ff == $past(count_ff) + CntW'(1))
      else $error("push with room did not store");
`endif

endmodule

`default_nettype wire

### rtl/asf_back.sv
`default_nettype none

module asf_back #(
   parameter int FADE_FRAMES = 64,
   localparam int NumW = $clog2(FADE_FRAMES + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   output logic                          q_ready,
   input  asf_pkg::job_type              q_job,
   input  logic [NumW-1:0]               q_num,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [asf_pkg::RspDataW-1:0]  rsp_tdata
);

   localparam int SW         = asf_pkg::SampleW;
   localparam int ProdW      = SW + NumW;
   localparam int LogF       = $clog2(FADE_FRAMES);
   localparam int RecipShift = ProdW + LogF;
   localparam int MultW      = ProdW + 1;
   localparam int WideW      = ProdW + MultW;
   localparam logic [63:0] RecipPow  = 64'd1 << RecipShift;
   localparam logic [63:0] RecipFull = (RecipPow + 64'(FADE_FRAMES) - 64'd1) / 64'(FADE_FRAMES);
   localparam logic [MultW-1:0] RecipMult = RecipFull[MultW-1:0];

   logic                s1_v_ff, out_v_ff;
   logic                s1_adv, out_adv;
   asf_pkg::job_type    s1_job_ff;
   logic [ProdW-1:0]    s1_prod_l_ff, s1_prod_r_ff, prod_l_in, prod_r_in;
   logic                s1_neg_l_ff, s1_neg_r_ff;
   logic [SW-1:0]       mag_l, mag_r;
   logic [WideW-1:0]    wide_l, wide_r;
   logic [SW-1:0]       quo_l, quo_r, res_l, res_r;
   logic [asf_pkg::RspDataW-1:0] out_data_ff, out_data_in;

   // Pipeline advance from the output back.
   assign out_adv = !out_v_ff || rsp_tready;
   assign s1_adv  = !s1_v_ff || out_adv;
   assign q_ready = s1_adv;

   // Stage one: sample magnitude times fade numerator.
   assign mag_l     = q_job.left[SW-1] ? (SW'(0) - q_job.left) : q_job.left;
   assign mag_r     = q_job.right[SW-1] ? (SW'(0) - q_job.right) : q_job.right;
   assign prod_l_in = ProdW'(mag_l) * ProdW'(q_num);
   assign prod_r_in = ProdW'(mag_r) * ProdW'(q_num);

   // Stage two: divide by the fade length through an exact reciprocal, then restore sign.
   assign wide_l = WideW'(s1_prod_l_ff) * WideW'(RecipMult);
   assign wide_r = WideW'(s1_prod_r_ff) * WideW'(RecipMult);
   assign quo_l  = wide_l[RecipShift +: SW];
   assign quo_r  = wide_r[RecipShift +: SW];
   assign res_l  = s1_neg_l_ff ? (SW'(0) - quo_l) : quo_l;
   assign res_r  = s1_neg_r_ff ? (SW'(0) - quo_r) : quo_r;

   assign out_data_in = {3'b000, s1_job_ff.fill_level, s1_job_ff.underrun_total,
                         s1_job_ff.accepted, s1_job_ff.supplied, res_r, res_l};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (s1_adv) begin
            s1_v_ff <= q_valid;
         end
         if (out_adv) begin
            out_v_ff <= s1_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_job_ff    <= q_job;
         s1_prod_l_ff <= prod_l_in;
         s1_prod_r_ff <= prod_r_in;
         s1_neg_l_ff  <= q_job.left[SW-1];
         s1_neg_r_ff  <= q_job.right[SW-1];
      end
      if (out_adv) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire

### tb/tb.sv
module tb;

   localparam int DEPTH = 1024;
   localparam int FADE = 64;
   // Longest run of cycles with no word moving on any channel. The worst
   // case is a 79 percent receiver stall behind the pipeline, or the short
   // pause before a threshold write; this limit leaves a wide margin for
   // either.
   localparam int STALL_LIMIT = 2000;
   // The two-bit kind field has one code that the block does not use.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // left_in [15:0], right_in [31:16]
   logic [1:0]  req_tuser = '0;   // kind [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // left_out, right_out, supplied, accepted,
                                  // underrun_total, fill_level
   logic        csr_tvalid = 1'b0;
   logic        csr_tready;
   logic [15:0] csr_tdata = '0;   // start_threshold [10:0]

   int send_idle_pct = 36;
   int recv_idle_pct = 79;
   int stall_cycles = 0;

   // Tracks the audio FIFO state and holds the results still owed by the block.
   class audio_fifo_scoreboard;
      typedef struct {
         logic [asf_pkg::SampleW-1:0]   left;
         logic [asf_pkg::SampleW-1:0]   right;
         logic                          supplied;
         logic                          accepted;
         logic [asf_pkg::UnderrunW-1:0] underruns;
         logic [asf_pkg::LevelW-1:0]    level;
      } audio_result_type;

      bit [31:0]        frames [DEPTH];
      audio_result_type owed_results [$];
      int               rd_ptr;
      int               wr_ptr;
      int               level;
      int               fade_left;
      int               underruns;
      int               threshold;
      bit               waiting;
      int               errors;

      function new();
         rd_ptr = 0;
         wr_ptr = 0;
         level = 0;
         fade_left = FADE;
         underruns = 0;
         threshold = 256;
         waiting = 1'b1;
         errors = 0;
      endfunction

      function void set_threshold(logic [asf_pkg::LevelW-1:0] value);
         threshold = value;
      endfunction

      function int pending();
         return owed_results.size();
      endfunction

      // Apply one accepted request word and queue the result it should give.
      function void note_request(logic [1:0] kind, logic [15:0] left_in,
                                 logic [15:0] right_in);
         audio_result_type res;
         bit [31:0]        frame;
         int               left_s;
         int               right_s;
         int               gain;
         bit               playing;
         res = '{default: '0};
         case (kind)
            asf_pkg::KIND_PUSH: begin
               if (level < DEPTH) begin
                  frames[wr_ptr] = {right_in, left_in};
                  wr_ptr = (wr_ptr + 1) % DEPTH;
                  level++;
                  res.accepted = 1'b1;
               end
            end
            asf_pkg::KIND_PULL: begin
               // Waiting ends once the level reaches the threshold.
               playing = !waiting || level >= threshold;
               if (playing)
                  waiting = 1'b0;
               if (playing && level > 0) begin
                  frame = frames[rd_ptr];
                  rd_ptr = (rd_ptr + 1) % DEPTH;
                  level--;
                  left_s = $signed(frame[15:0]);
                  right_s = $signed(frame[31:16]);
                  // Fade-in ramp after reset or a restart, truncating toward zero.
                  if (fade_left != 0) begin
                     gain = FADE - fade_left + 1;
                     left_s = left_s * gain / FADE;
                     right_s = right_s * gain / FADE;
                     fade_left--;
                  end
                  res.supplied = 1'b1;
                  res.left = left_s[15:0];
                  res.right = right_s[15:0];
               end else begin
                  // Running dry while playing is an underrun.
                  if (!waiting && underruns < 65535)
                     underruns++;
                  waiting = 1'b1;
               end
            end
            asf_pkg::KIND_RESTART: begin
               rd_ptr = 0;
               wr_ptr = 0;
               level = 0;
               waiting = 1'b1;
               fade_left = FADE;
            end
            default: ;
         endcase
         res.underruns = underruns[15:0];
         res.level = level[10:0];
         owed_results.insert(owed_results.size(), res);
      endfunction

      // Compare one result word with the oldest owed result.
      function void check_result(logic [63:0] word);
         audio_result_type want;
         if (owed_results.size() == 0) begin
            $error("result word %h arrived with no request pending", word);
            errors++;
            return;
         end
         want = owed_results.pop_front();
         if (word[15:0] !== want.left) begin
            $error("left_out: expected %0d, actual %0d", $signed(want.left),
                   $signed(word[15:0]));
            errors++;
         end
         if (word[31:16] !== want.right) begin
            $error("right_out: expected %0d, actual %0d", $signed(want.right),
                   $signed(word[31:16]));
            errors++;
         end
         if (word[32] !== want.supplied) begin
            $error("supplied: expected %0d, actual %0d", want.supplied, word[32]);
            errors++;
         end
         if (word[33] !== want.accepted) begin
            $error("accepted: expected %0d, actual %0d", want.accepted, word[33]);
            errors++;
         end
         if (word[49:34] !== want.underruns) begin
            $error("underrun_total: expected %0d, actual %0d", want.underruns,
                   word[49:34]);
            errors++;
         end
         if (word[60:50] !== want.level) begin
            $error("fill_level: expected %0d, actual %0d", want.level, word[60:50]);
            errors++;
         end
      endfunction
   endclass

   audio_fifo_scoreboard sb;

   audio_sink_fifo_with_starve_recovery_top #(
      .FIFO_DEPTH (DEPTH),
      .FADE_FRAMES(FADE)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_tvalid(csr_tvalid),
      .csr_tready(csr_tready),
      .csr_tdata (csr_tdata)
   );

   always #4 clock = ~clock;

   // Result side: check each word taken, then pick the next ready value.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog on cycles in which no word moves on any channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_tvalid && csr_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Biased toward full-scale values and minus one so the sign and top bits get exercised.
   function automatic logic [15:0] random_sample();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   // Offer one request word, with random gaps ahead of it.
   task automatic send_word(input logic [1:0] kind, input logic [15:0] left_in,
                            input logic [15:0] right_in);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {right_in, left_in};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sb.note_request(kind, left_in, right_in);
   endtask

   task automatic push_frames(input int count);
      repeat (count)
         send_word(asf_pkg::KIND_PUSH, random_sample(), random_sample());
   endtask

   task automatic pull_frames(input int count);
      repeat (count)
         send_word(asf_pkg::KIND_PULL, 16'($urandom), 16'($urandom));
   endtask

   // Let the block go idle, then write the start threshold.
   task automatic write_threshold(input logic [asf_pkg::LevelW-1:0] value);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (4)
         @(posedge clock);
      csr_tvalid <= 1'b1;
      csr_tdata <= {5'b0, value};
      @(posedge clock);
      while (!csr_tready)
         @(posedge clock);
      sb.set_threshold(value);
      csr_tvalid <= 1'b0;
   endtask

   // Bursts of pushes and pulls so the level swings across the threshold,
   // with the odd restart and unused code mixed in.
   task automatic random_traffic(input int items);
      int          sent;
      int          len;
      int unsigned pick;
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(99);
         len = $urandom_range(1, 48);
         if (pick < 45) begin
            push_frames(len);
         end else if (pick < 90) begin
            pull_frames(len);
         end else if (pick < 95) begin
            send_word(asf_pkg::KIND_RESTART, random_sample(), random_sample());
            len = 1;
         end else begin
            send_word(KIND_UNUSED, random_sample(), random_sample());
            len = 0;
         end
         sent += len;
      end
   endtask

   initial begin
      sb = new();
      repeat (12)
         @(posedge clock);
      reset <= 1'b0;

      // Directed: waiting, fade start, draining into an underrun, restart.
      write_threshold(11'd4);
      send_word(asf_pkg::KIND_PULL, 16'h0000, 16'h0000);
      send_word(KIND_UNUSED, 16'hffff, 16'hffff);
      send_word(asf_pkg::KIND_PUSH, 16'h7fff, 16'h8000);
      send_word(asf_pkg::KIND_PUSH, 16'h8000, 16'h7fff);
      send_word(asf_pkg::KIND_PUSH, 16'hffff, 16'h0001);
      send_word(asf_pkg::KIND_PULL, 16'h0000, 16'h0000);
      send_word(asf_pkg::KIND_PUSH, 16'h0000, 16'h0000);
      send_word(asf_pkg::KIND_PUSH, 16'h8000, 16'h8000);
      pull_frames(5);
      send_word(asf_pkg::KIND_PULL, 16'hffff, 16'hffff);
      send_word(asf_pkg::KIND_PULL, 16'h0000, 16'h0000);
      send_word(KIND_UNUSED, 16'h0000, 16'h0000);
      send_word(asf_pkg::KIND_RESTART, 16'h0000, 16'h0000);
      send_word(asf_pkg::KIND_PUSH, 16'h3039, 16'hcfc7);
      send_word(asf_pkg::KIND_PULL, 16'h0000, 16'h0000);

      // Slow receiver.
      write_threshold(11'd1);
      random_traffic(80);
      write_threshold(11'($urandom_range(2, 48)));
      random_traffic(80);

      // Slow sender: fill to the brim, drain past the fade, refill past full.
      send_idle_pct = 79;
      recv_idle_pct = 36;
      write_threshold(11'd1024);
      send_word(asf_pkg::KIND_RESTART, 16'h0000, 16'h0000);
      push_frames(DEPTH + 6);
      pull_frames(FADE + 6);
      push_frames(FADE + 16);
      send_word(asf_pkg::KIND_RESTART, 16'h0000, 16'h0000);
      write_threshold(11'h7ff);
      random_traffic(40);

      // No idling from here on.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_threshold(11'd0);
      random_traffic(60);
      write_threshold(11'($urandom_range(1, 32)));
      random_traffic(60);

      req_tvalid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (10)
         @(posedge clock);
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### files.f
rtl/asf_pkg.sv
rtl/asf_ram.sv
rtl/asf_queue.sv
rtl/asf_front.sv
rtl/asf_back.sv
rtl/audio_sink_fifo_with_starve_recovery_top.sv
tb/tb.sv
